/* sv/dip_pkg.sv */
// Shared types and constants for the decimal integer stream parser.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package dip_pkg;

  localparam int unsigned ValueWidth   = 17;
  localparam int unsigned TickWidth    = 16;
  localparam int unsigned AccWidth     = 16;
  localparam int unsigned ApbAddrWidth = 3;
  localparam int unsigned ApbDataWidth = 32;

  localparam logic [TickWidth-1:0] TimeoutReset = 16'd2000;
  localparam logic [TickWidth-1:0] TickMax      = 16'hFFFF;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharMinus = 8'h2D;

  // Operation codes carried with every input transfer.
  localparam logic OpChar = 1'b0;
  localparam logic OpTick = 1'b1;

  // Register index of the timeout register, taken from paddr[2].
  localparam logic RegTimeout = 1'b0;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_char;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         timed_out;
  } out_item_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CharZero) && (c <= CharNine);
  endfunction

endpackage

`default_nettype wire

/* sv/dip_apb_regs.sv */
// APB-style configuration register file holding the search timeout.
// Depends on dip_pkg.
`default_nettype none

module dip_apb_regs (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [dip_pkg::ApbAddrWidth-1:0]     paddr,
  input  wire logic [dip_pkg::ApbDataWidth-1:0]     pwdata,
  output logic      [dip_pkg::ApbDataWidth-1:0]     prdata,
  output logic                                      pready,
  output logic      [dip_pkg::TickWidth-1:0]        timeout_o
);
  import dip_pkg::*;

  logic [TickWidth-1:0] timeout_q;
  logic [TickWidth-1:0] timeout_d;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == RegTimeout);

  always_comb begin
    timeout_d = timeout_q;
    if (wr_en) begin
      timeout_d = pwdata[TickWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else begin
      timeout_q <= timeout_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegTimeout) begin
      prdata = {{(ApbDataWidth-TickWidth){1'b0}}, timeout_q};
    end
  end

  assign timeout_o = timeout_q;

endmodule

`default_nettype wire

/* sv/dip_in_stage.sv */
// Input register stage: captures one input transfer and holds it until the
// parser consumes it. Depends on dip_pkg.
`default_nettype none

module dip_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire dip_pkg::in_item_t in_item_i,
  input  wire logic              consume_i,
  output logic                   valid_o,
  output dip_pkg::in_item_t      item_o
);
  import dip_pkg::*;

  logic     valid_q;
  logic     valid_d;
  in_item_t item_q;
  logic     take;

  assign in_ready_o = !valid_q || consume_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* sv/dip_parser.sv */
// Parser state update and result register: one input item per cycle while the result register is free or being read.
// Depends on dip_pkg.
`default_nettype none

module dip_parser (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire dip_pkg::in_item_t               item_i,
  output logic                                 consume_o,
  input  wire logic [dip_pkg::TickWidth-1:0]   timeout_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output dip_pkg::out_item_t                   out_item_o
);
  import dip_pkg::*;

  logic                 in_number_q, in_number_d;
  logic [7:0]           prev_q, prev_d;
  logic [AccWidth-1:0]  acc_q, acc_d;
  logic [TickWidth-1:0] tick_q, tick_d;
  logic                 neg_q, neg_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_item_q, out_item_d;

  logic                 fire;
  logic                 emit;
  logic                 digit;
  logic [AccWidth-1:0]  digit_val;
  logic [TickWidth-1:0] tick_inc;
  logic [ValueWidth-1:0] mag;

  assign fire      = valid_i && (!out_valid_q || out_ready_i);
  assign consume_o = fire;
  assign digit     = is_digit(item_i.rx_char);
  assign digit_val = {{(AccWidth-8){1'b0}}, item_i.rx_char - CharZero};
  assign tick_inc  = (tick_q == TickMax) ? tick_q : tick_q + 1'b1;
  assign mag       = {acc_q[AccWidth-1], acc_q};

  always_comb begin
    in_number_d = in_number_q;
    prev_d      = prev_q;
    acc_d       = acc_q;
    tick_d      = tick_q;
    neg_d       = neg_q;
    emit        = 1'b0;
    out_item_d  = out_item_q;
    if (fire) begin
      if (item_i.operation == OpTick) begin
        tick_d = tick_inc;
        if (!in_number_q && (tick_inc >= timeout_i)) begin
          emit                 = 1'b1;
          out_item_d.value     = '0;
          out_item_d.timed_out = 1'b1;
          tick_d               = '0;
        end
      end else if (!in_number_q) begin
        if (digit) begin
          in_number_d = 1'b1;
          neg_d       = (prev_q == CharMinus);
          acc_d       = digit_val;
        end else begin
          prev_d = item_i.rx_char;
        end
      end else if (digit) begin
        // Times ten as two shifts and an add, wrapping at 16 bits.
        acc_d = (acc_q << 3) + (acc_q << 1) + digit_val;
      end else begin
        emit                 = 1'b1;
        out_item_d.value     = neg_q ? -mag : mag;
        out_item_d.timed_out = 1'b0;
        in_number_d          = 1'b0;
        prev_d               = item_i.rx_char;
        tick_d               = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_number_q <= 1'b0;
      prev_q      <= '0;
      acc_q       <= '0;
      tick_q      <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_number_q <= in_number_d;
      prev_q      <= prev_d;
      acc_q       <= acc_d;
      tick_q      <= tick_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

/* sv/decimal_integer_stream_parser.sv */
// Top level of the decimal integer stream parser: input stage, parser and
// configuration registers. Depends on dip_pkg, dip_in_stage, dip_parser, dip_apb_regs.
//
// Usage. The input channel carries items of type in_item_t: either a received
// byte (operation OpChar) or a one millisecond tick (operation OpTick). Each
// transfer is taken on a valid/ready handshake. The output channel carries
// out_item_t results: a signed 17-bit value and a timeout flag. A number is
// emitted when a non-digit byte ends it; a zero with timed_out set is emitted
// when the tick count reaches the timeout while no number is in progress.
// The input register captures a transfer when it is accepted; the parser takes
// it once the result register is free or being read, and when a result is
// emitted loads it into the result register and raises out_valid_o. Throughput
// is one item per cycle while the receiver takes results; the state update of
// the parser is the only loop, and the input register keeps accepting while a
// finished result waits, so a stalled receiver only holds the input back
// once both the result register and the input register are full.
// Reset clears the parser state and the result valid flag and loads the
// timeout register with 2000 ticks. The timeout register sits at byte
// address 0 of the APB-style port; pready is always high.
`default_nettype none

module decimal_integer_stream_parser (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire dip_pkg::in_item_t                in_item_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output dip_pkg::out_item_t                    out_item_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [dip_pkg::ApbAddrWidth-1:0] paddr,
  input  wire logic [dip_pkg::ApbDataWidth-1:0] pwdata,
  output logic      [dip_pkg::ApbDataWidth-1:0] prdata,
  output logic                                  pready
);
  import dip_pkg::*;

  logic                 stage_valid;
  in_item_t             stage_item;
  logic                 consume;
  logic [TickWidth-1:0] timeout;

  // Input register: decouples the input handshake from the parser.
  dip_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .consume_i  (consume),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  // Parser: updates the state and loads the result register.
  dip_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid),
    .item_i      (stage_item),
    .consume_o   (consume),
    .timeout_i   (timeout),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // Configuration registers.
  dip_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .timeout_o (timeout)
  );

  // A timeout result always carries the value zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.timed_out |-> out_item_o.value == '0)
    else $error("timeout result with non-zero value");

  // The input side only stalls when both stages are full and the output is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> stage_valid && out_valid_o && !out_ready_i)
    else $error("input stalled without a full pipeline");

  // A write to the timeout register takes effect at the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[2] == RegTimeout)
      |=> timeout == $past(pwdata[TickWidth-1:0]))
    else $error("timeout register not updated by write");

  // The parser only consumes an item that the input stage holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume |-> stage_valid)
    else $error("parser consumed an empty input stage");

endmodule

`default_nettype wire
